/* sv/kth_set_bit_select_top_macros.svh */
// Assertion helpers used by the kth_set_bit_select_top RTL file.
`ifndef KTH_SET_BIT_SELECT_TOP_MACROS_SVH
`define KTH_SET_BIT_SELECT_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KSSEL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KSSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/kssel_pkg.sv */
`timescale 1ns / 1ps

package kssel_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int IDX_W        = 10;
    localparam int RANK_W       = 10;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_TOGGLE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  index;
        logic              bit_value;
        logic [RANK_W-1:0] rank;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] position;
        logic             found;
    } result_t;

endpackage

/* sv/kth_set_bit_select_top.sv */
`timescale 1ns / 1ps
// Rank select over a bitmap: find the position of the (rank+1)-th set bit.
// Command channel: an item (cmd) is taken on a clock edge with start high and
// busy low. func selects write bit, toggle bit or find; func 3 and a write or
// toggle at an index at or beyond CAPACITY are dropped without a result.
// Result channel: only find answers. done is high for exactly one cycle with
// result valid; the receiver must take it then, there is no stall.
// found is low (position zero) when fewer than rank+1 bits are set.
// State: one RAM holds a heap-ordered count tree of 2*2^L nodes, L =
// clog2(CAPACITY); the leaves are the bitmap itself.
// Find: a root check, then one dependent RAM read per tree level, down to
// the leaf; it ends at the root check when too few bits are set.
// Write/toggle keeps busy high for a leaf read, then one read-modify-write
// per level on the root-to-leaf path; it ends at the leaf read when the
// bit does not change. The next item can be accepted once busy is low,
// which is already so in the cycle in which done is high. Items do not
// overlap: each tree level's RAM read hangs on the one before it.
// Reset: after rst_n rises the tree RAM is cleared one entry per cycle,
// all 2*2^L entries; busy stays high meanwhile.

module kth_set_bit_select_top
    import kssel_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

`include "kth_set_bit_select_top_macros.svh"

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int AW     = LEVELS + 1;
    localparam int DEPTH  = 2 ** AW;
    localparam int LEAVES = 2 ** LEVELS;
    localparam int CW     = AW;
    localparam int WW     = (CW > RANK_W + 1) ? CW : RANK_W + 1;
    localparam int XW     = AW + IDX_W;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_UPD_OLD   = 3'd2;
    localparam logic [2:0] S_UPD_WALK  = 3'd3;
    localparam logic [2:0] S_FIND_ROOT = 3'd4;
    localparam logic [2:0] S_FIND_WALK = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [LEVELS-1:0] rem_reg, rem_next;
    logic [WW-1:0]     want_reg, want_next;
    logic              up_reg, up_next;
    logic [1:0]        func_reg, func_next;
    logic              bitv_reg, bitv_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CW-1:0]     ram_rdata;

    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     leaf_x;
    logic              in_range;
    logic [WW-1:0]     cnt_x;
    logic              new_bit;
    logic [AW-1:0]     child;
    logic [LEVELS+IDX_W-1:0] pos_x;

    kssel_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_x    = XW'(cmd.index);
    assign in_range = idx_x < XW'(CAPACITY);
    assign leaf_x   = idx_x + XW'(LEAVES);
    assign cnt_x    = WW'(ram_rdata);
    assign new_bit  = (func_reg == FUNC_WRITE) ? bitv_reg : ~ram_rdata[0];

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        node_next   = node_reg;
        rem_next    = rem_reg;
        want_next   = want_reg;
        up_next     = up_reg;
        func_next   = func_reg;
        bitv_next   = bitv_reg;
        ram_we      = 1'b0;
        ram_waddr   = node_reg;
        ram_wdata   = '0;
        ram_raddr   = '0;
        child       = '0;
        pos_x       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                func_next = cmd.func;
                bitv_next = cmd.bit_value;
                rem_next  = idx_x[LEVELS-1:0];
                want_next = WW'(cmd.rank) + WW'(1);
                if (start)
                begin
                    if ((cmd.func == FUNC_WRITE || cmd.func == FUNC_TOGGLE) && in_range)
                    begin
                        ram_raddr  = leaf_x[AW-1:0];
                        state_next = S_UPD_OLD;
                    end
                    else if (cmd.func == FUNC_FIND)
                    begin
                        ram_raddr  = AW'(1);
                        state_next = S_FIND_ROOT;
                    end
                end
            end

            S_UPD_OLD:
            begin
                // leaf count is the stored bit
                if (new_bit != ram_rdata[0])
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = {1'b1, rem_reg};
                    ram_wdata  = CW'(new_bit);
                    ram_raddr  = AW'(1);
                    node_next  = AW'(1);
                    up_next    = new_bit;
                    state_next = S_UPD_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_UPD_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = up_reg ? ram_rdata + CW'(1) : ram_rdata - CW'(1);
                child     = {node_reg[AW-2:0], rem_reg[LEVELS-1]};
                rem_next  = rem_reg << 1;
                if (child[AW-1])
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_raddr = child;
                    node_next = child;
                end
            end

            S_FIND_ROOT:
            begin
                if (cnt_x < want_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    node_next  = AW'(1);
                    ram_raddr  = AW'(2);
                    state_next = S_FIND_WALK;
                end
            end

            S_FIND_WALK:
            begin
                // rdata is the left child's count
                if (want_reg <= cnt_x)
                begin
                    child = {node_reg[AW-2:0], 1'b0};
                end
                else
                begin
                    child     = {node_reg[AW-2:0], 1'b1};
                    want_next = want_reg - cnt_x;
                end
                pos_x = (LEVELS + IDX_W)'(child[LEVELS-1:0]);
                if (child[AW-1])
                begin
                    done_next            = 1'b1;
                    result_next.position = pos_x[IDX_W-1:0];
                    result_next.found    = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    node_next = child;
                    ram_raddr = {child[AW-2:0], 1'b0};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        node_reg   <= node_next;
        rem_reg    <= rem_next;
        want_reg   <= want_next;
        up_reg     <= up_next;
        func_reg   <= func_next;
        bitv_reg   <= bitv_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `KSSEL_ASSERT_NOW(a_notfound_zero, done && !result.found, result.position == '0, "miss with nonzero position")
    `KSSEL_ASSERT_NEXT(a_find_busy, start && !busy && cmd.func == FUNC_FIND, busy, "find accepted but not busy")
    `KSSEL_ASSERT_NEXT(a_done_single, done, !done, "done held for two cycles")
    `KSSEL_ASSERT_NOW(a_walk_internal, state_reg == S_UPD_WALK, !node_reg[AW-1], "count update hit a leaf")

endmodule

/* sv/kssel_ram.sv */
`timescale 1ns / 1ps

module kssel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
